// ===== rtl/core/ccr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ccr_pkg;

	localparam int REPLY_MAX = 6;
	localparam int CNT_W     = 3;

	localparam logic [7:0] DEV_ADDRESS = 8'h31;
	localparam logic [7:0] REPLY_FLAG  = 8'h80;

	// command codes
	localparam logic [7:0] CMD_CONT_ON   = 8'h17;
	localparam logic [7:0] CMD_CONT_OFF  = 8'h18;
	localparam logic [7:0] CMD_TELEMETRY = 8'h22;
	localparam logic [7:0] CMD_SET_V     = 8'h34;
	localparam logic [7:0] CMD_SET_V_SAVE = 8'h35;
	localparam logic [7:0] CMD_STATE     = 8'h12;
	localparam logic [7:0] CMD_VERIFY    = 8'h2A;

	// expected length bytes
	localparam logic [7:0] LEN_CONT  = 8'h02;
	localparam logic [7:0] LEN_SET_V = 8'h04;
	localparam logic [7:0] LEN_NONE  = 8'h00;

	// contactor selectors
	localparam logic [7:0] SEL_MAIN     = 8'h01;
	localparam logic [7:0] SEL_MAIN_HI  = 8'h10;
	localparam logic [7:0] SEL_SW       = 8'h02;
	localparam logic [7:0] SEL_SW_HI    = 8'h20;
	localparam logic [7:0] SEL_BOTH     = 8'h03;
	localparam logic [7:0] SEL_BOTH_HI  = 8'h30;

	typedef struct packed {
		logic [7:0] dev_addr;
		logic [7:0] cmd;
		logic [7:0] data_len;
		logic [7:0] data0;
		logic [7:0] data1;
		logic [7:0] data2;
	} frame_t;

	typedef struct packed {
		logic [7:0]  reply_byte;
		logic        reply_last;
		logic        main_contactor_on;
		logic        switched_contactor_on;
		logic        voltage_valid;
		logic [15:0] voltage_word;
	} reply_beat_t;

	// one decoded reply, handed from decode to serializer
	typedef struct packed {
		logic                            ok;
		logic [CNT_W-1:0]                n;
		logic [REPLY_MAX-1:0][7:0]       bytes;
		logic                            main_on;
		logic                            switched_on;
		logic                            vvalid;
		logic [15:0]                     vword;
	} reply_rec_t;

endpackage
`default_nettype wire

// ===== rtl/core/ccr_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ccr_decode (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ccr_pkg::frame_t frame,
	input  wire logic            commit,
	output ccr_pkg::reply_rec_t  rec
);
	import ccr_pkg::*;

	logic main_q, switched_q;
	logic main_d, switched_d;
	logic ok, is_on_off;
	logic [7:0] status_byte;

	always_comb begin
		ok        = 1'b0;
		is_on_off = 1'b0;
		rec       = '0;
		status_byte = {6'd0, switched_q, main_q};
		rec.bytes[0] = DEV_ADDRESS;
		rec.bytes[1] = frame.cmd | REPLY_FLAG;
		rec.bytes[2] = 8'h01;
		rec.n        = CNT_W'(4);
		case (frame.cmd)
			CMD_CONT_ON, CMD_CONT_OFF: begin
				ok        = (frame.data_len == LEN_CONT);
				is_on_off = 1'b1;
			end
			CMD_TELEMETRY: begin
				ok = (frame.data_len == LEN_NONE);
				rec.bytes[2] = 8'h03;
				rec.n        = CNT_W'(6);
			end
			CMD_SET_V, CMD_SET_V_SAVE: begin
				ok         = (frame.data_len == LEN_SET_V);
				rec.vvalid = 1'b1;
				rec.vword  = {frame.data2, frame.data1};
			end
			CMD_STATE: begin
				ok = (frame.data_len == LEN_NONE);
				rec.bytes[2] = 8'h02;
				rec.bytes[3] = status_byte;
				// checksum over a single byte is the byte itself
				rec.bytes[4] = status_byte;
				rec.n        = CNT_W'(5);
			end
			CMD_VERIFY: begin
				ok = (frame.data_len == LEN_NONE);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		ok     = ok && (frame.dev_addr == DEV_ADDRESS);
		rec.ok = ok;
		if (!rec.vvalid || !ok) begin
			rec.vword  = '0;
			rec.vvalid = 1'b0;
		end

		main_d     = main_q;
		switched_d = switched_q;
		if (ok && is_on_off) begin
			case (frame.data0)
				SEL_MAIN, SEL_MAIN_HI: begin
					main_d = (frame.cmd == CMD_CONT_ON);
				end
				SEL_SW, SEL_SW_HI: begin
					switched_d = (frame.cmd == CMD_CONT_ON);
				end
				SEL_BOTH, SEL_BOTH_HI: begin
					main_d     = (frame.cmd == CMD_CONT_ON);
					switched_d = (frame.cmd == CMD_CONT_ON);
				end
				default: begin
					main_d = main_q;
				end
			endcase
		end
		rec.main_on     = main_d;
		rec.switched_on = switched_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_q     <= 1'b0;
			switched_q <= 1'b0;
		end else if (commit) begin
			main_q     <= main_d;
			switched_q <= switched_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ccr_serializer.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ccr_serializer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire ccr_pkg::reply_rec_t rec,
	output logic                     can_load,
	output logic                     reply_valid,
	input  wire logic                reply_stall,
	output ccr_pkg::reply_beat_t     reply
);
	import ccr_pkg::*;

	logic                      valid_q;
	logic [CNT_W-1:0]          remain_q;
	logic [REPLY_MAX-1:0][7:0] bytes_q;
	logic                      main_q, switched_q, vvalid_q;
	logic [15:0]               vword_q;
	logic                      consume, last;

	assign last     = (remain_q == CNT_W'(1));
	assign consume  = valid_q && !reply_stall;
	assign can_load = !valid_q || (consume && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			remain_q <= '0;
		end else if (load) begin
			valid_q  <= 1'b1;
			remain_q <= rec.n;
		end else if (consume) begin
			valid_q  <= !last;
			remain_q <= remain_q - CNT_W'(1);
		end
	end

	// payload: shift one byte out per beat
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q    <= rec.bytes;
			main_q     <= rec.main_on;
			switched_q <= rec.switched_on;
			vvalid_q   <= rec.vvalid;
			vword_q    <= rec.vword;
		end else if (consume) begin
			bytes_q <= {8'h00, bytes_q[REPLY_MAX-1:1]};
		end
	end

	assign reply_valid                 = valid_q;
	assign reply.reply_byte            = bytes_q[0];
	assign reply.reply_last            = last;
	assign reply.main_contactor_on     = main_q;
	assign reply.switched_contactor_on = switched_q;
	assign reply.voltage_valid         = vvalid_q;
	assign reply.voltage_word          = vword_q;

endmodule
`default_nettype wire

// ===== rtl/core/contactor_command_responder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Contactor command responder for device address 0x31.
// Frame channel (frame_valid / frame_stall / frame): one received command
// frame per beat. Reply channel (reply_valid / reply_stall / reply): one reply
// byte per beat, reply_last marks the final byte; contactor flags and the
// voltage word ride along on every beat of that reply.
// Path: a frame accepted into the input register is decoded there and loaded
// into the reply shifter once it can load, and the shifter register then
// offers its first reply byte.
// Throughput: the reply shifter sends one byte per cycle while reply_stall is
// low; a recognized frame's reply is 4, 5 or 6 bytes, by command; a new frame
// is accepted while the previous reply drains. Unrecognized frames are dropped
// with no reply and no state change.
// Reset clears both contactor flags (off) and empties both registers.
// A stalled reply holds its byte; a recognized frame waiting in the input
// register raises frame_stall until the shifter takes the reply's last byte.
module contactor_command_responder (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 frame_valid,
	output logic                      frame_stall,
	input  wire ccr_pkg::frame_t      frame,
	output logic                      reply_valid,
	input  wire logic                 reply_stall,
	output ccr_pkg::reply_beat_t      reply
);
	import ccr_pkg::*;

	logic       valid_s1;
	frame_t     frame_s1;
	reply_rec_t rec;
	logic       can_load;
	logic       advance;

	// the held frame leaves when dropped or when the shifter takes it
	assign advance     = valid_s1 && (!rec.ok || can_load);
	assign frame_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!frame_stall) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_valid && !frame_stall) begin
			frame_s1 <= frame;
		end
	end

	ccr_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_s1),
		.commit (advance),
		.rec    (rec)
	);

	ccr_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && rec.ok),
		.rec         (rec),
		.can_load    (can_load),
		.reply_valid (reply_valid),
		.reply_stall (reply_stall),
		.reply       (reply)
	);

endmodule
`default_nettype wire
